### design/pes_pkg.sv
`timescale 1ns / 1ps

package pes_pkg;

    // Pool geometry
    localparam int SLOTS      = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int SLOT_IDX_W = 6;

    // Field widths
    localparam int LIFE_W     = 21;
    localparam int POS_W      = 32;
    localparam int TIMER_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // 0.99 in unsigned Q0.16, rounded
    localparam logic [15:0] DAMP_Q16 = 16'd64881;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SECONDS  = 3'd7;

    typedef struct packed {
        logic [15:0]              emit_interval_ms;
        logic [19:0]              lifetime_ms;
        logic signed [POS_W-1:0]  start_x;
        logic signed [POS_W-1:0]  start_y;
        logic signed [POS_W-1:0]  start_vel_x;
        logic signed [POS_W-1:0]  start_vel_y;
        logic [9:0]               tick_ms;
        logic [15:0]              tick_seconds;
    } cfg_t;

    // One slot as stored in the slot memory
    typedef struct packed {
        logic signed [LIFE_W-1:0] life;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  vel_x;
        logic signed [POS_W-1:0]  vel_y;
    } slot_ent_t;

    localparam int SLOT_ENT_W = $bits(slot_ent_t);

    // Sequencer to slot pipeline
    typedef struct packed {
        logic             start;
        logic             emit;
        logic             valid;
        logic [IDX_W-1:0] idx;
    } issue_t;

    // Slot pipeline to sequencer
    typedef struct packed {
        logic adv;
        logic busy;
    } pipe_stat_t;

    // floor((v * q + 2^15) / 2^16), one 32 x 17 product
    function automatic logic signed [POS_W:0] mul_round(
        input logic signed [POS_W-1:0] v,
        input logic [15:0]              q
    );
        logic signed [48:0] prod;
        prod = 49'(v) * $signed({33'b0, q});
        prod = prod + 49'sd32768;
        return prod[48:16];
    endfunction

    // Signed add of a position and a step, clamped to the position range
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W:0]   d
    );
        logic signed [POS_W+1:0] s;
        s = (POS_W + 2)'(a) + (POS_W + 2)'(d);
        if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111) begin
            return s[POS_W-1:0];
        end
        return s[POS_W+1] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
    endfunction

endpackage

### design/pes_ram.sv
`timescale 1ns / 1ps

module pes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pes_ctrl.sv
`timescale 1ns / 1ps

module pes_ctrl
    import pes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       emitter_on,
    input  pipe_stat_t stat,
    output issue_t     iss
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic                 accept;
    logic                 emit_now;
    logic [TIMER_W:0]     timer_sum;
    logic [TIMER_W-1:0]   interval;

    assign in_ready = (state_reg == ST_IDLE) && !stat.busy;
    assign accept   = in_valid && in_ready;

    // Emission decision and timer update
    assign interval  = TIMER_W'(cfg.emit_interval_ms);
    assign emit_now  = emitter_on && (timer_reg >= interval);
    assign timer_sum = {1'b0, timer_reg} + (TIMER_W + 1)'(cfg.tick_ms);

    always_comb
    begin
        timer_next = timer_reg;
        if (accept && emitter_on)
        begin
            if (emit_now)
            begin
                timer_next = timer_reg - interval;
            end
            else if (timer_sum[TIMER_W])
            begin
                timer_next = '1;
            end
            else
            begin
                timer_next = timer_sum[TIMER_W-1:0];
            end
        end
    end

    // Slot sweep sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (stat.adv)
                begin
                    if (idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            timer_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            timer_reg <= timer_next;
        end
    end

    assign iss.start = accept;
    assign iss.emit  = emit_now;
    assign iss.valid = (state_reg == ST_RUN);
    assign iss.idx   = idx_reg;

endmodule

### design/pes_slot_pipe.sv
`timescale 1ns / 1ps

module pes_slot_pipe
    import pes_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  issue_t                       iss,
    output pipe_stat_t                   stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SLOT_IDX_W-1:0]        slot_index,
    output logic                         alive,
    output logic signed [POS_W-1:0]      pos_x,
    output logic signed [POS_W-1:0]      pos_y,
    output logic signed [LIFE_W-1:0]     life_left,
    output logic                         last
);

    logic                     adv;
    logic [SLOTS-1:0]         vld_reg;
    logic                     pending_reg;

    // Read stage
    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic                     s1_vld_reg;
    logic [SLOT_ENT_W-1:0]    rd_data;
    slot_ent_t                rd_ent;
    slot_ent_t                new_ent;
    slot_ent_t                cur_ent;
    slot_ent_t                dmp_ent;
    logic signed [LIFE_W-1:0] life_raw;
    logic                     free;
    logic                     take;
    logic                     live;
    logic signed [POS_W:0]    damp_x;
    logic signed [POS_W:0]    damp_y;

    // Damped stage
    logic                     s2_valid_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic                     s2_live_reg;
    logic                     s2_wr_reg;
    slot_ent_t                s2_ent_reg;
    logic signed [POS_W:0]    step_x;
    logic signed [POS_W:0]    step_y;

    // Step stage
    logic                     s3_valid_reg;
    logic [IDX_W-1:0]         s3_idx_reg;
    logic                     s3_live_reg;
    logic                     s3_wr_reg;
    slot_ent_t                s3_ent_reg;
    logic signed [POS_W:0]    s3_dx_reg;
    logic signed [POS_W:0]    s3_dy_reg;
    slot_ent_t                wr_ent;
    logic                     wr_en;
    logic                     wr_alive;

    // Output register
    logic                     out_valid_reg;
    logic [SLOT_IDX_W-1:0]    slot_index_reg;
    logic                     alive_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic signed [LIFE_W-1:0] life_left_reg;
    logic                     last_reg;

    // Whole pipe moves when the output register can take a new item
    assign adv       = !out_valid_reg || out_ready;
    assign stat.adv  = adv;
    assign stat.busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    pes_ram #(
        .WIDTH (SLOT_ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s3_idx_reg),
        .wdata (wr_ent),
        .re    (adv && iss.valid),
        .raddr (iss.idx),
        .rdata (rd_data)
    );

    // Issue into the read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= iss.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= iss.idx;
            s1_vld_reg <= vld_reg[iss.idx];
        end
    end

    // Slot never written reads as free with zero life
    assign rd_ent   = slot_ent_t'(rd_data);
    assign life_raw = s1_vld_reg ? rd_ent.life : '0;
    assign free     = (life_raw <= 0);
    assign take     = pending_reg && free;

    assign new_ent.life  = LIFE_W'(cfg.lifetime_ms);
    assign new_ent.pos_x = cfg.start_x;
    assign new_ent.pos_y = cfg.start_y;
    assign new_ent.vel_x = cfg.start_vel_x;
    assign new_ent.vel_y = cfg.start_vel_y;

    // Place the new particle in the first free slot swept
    always_comb
    begin
        cur_ent      = rd_ent;
        cur_ent.life = life_raw;
        if (take)
        begin
            cur_ent = new_ent;
        end
    end

    assign live   = (cur_ent.life > 0);
    assign damp_x = mul_round(cur_ent.vel_x, DAMP_Q16);
    assign damp_y = mul_round(cur_ent.vel_y, DAMP_Q16);

    // Swap in the damped velocity for live slots
    always_comb
    begin
        dmp_ent = cur_ent;
        if (live)
        begin
            dmp_ent.vel_x = damp_x[POS_W-1:0];
            dmp_ent.vel_y = damp_y[POS_W-1:0];
        end
    end

    // Hold one pending emission per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (iss.start)
        begin
            pending_reg <= iss.emit;
        end
        else if (adv && s1_valid_reg && take)
        begin
            pending_reg <= 1'b0;
        end
    end

    // Damp velocity of live slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_idx_reg <= s1_idx_reg;
            s2_live_reg <= live;
            s2_wr_reg   <= live || take;
            s2_ent_reg  <= dmp_ent;
        end
    end

    // Position step from damped velocity
    assign step_x = mul_round(s2_ent_reg.vel_x, cfg.tick_seconds);
    assign step_y = mul_round(s2_ent_reg.vel_y, cfg.tick_seconds);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_idx_reg  <= s2_idx_reg;
            s3_live_reg <= s2_live_reg;
            s3_wr_reg   <= s2_wr_reg;
            s3_ent_reg  <= s2_ent_reg;
            s3_dx_reg   <= step_x;
            s3_dy_reg   <= step_y;
        end
    end

    // Advance position, drop life, write the slot back
    always_comb
    begin
        wr_ent = s3_ent_reg;
        if (s3_live_reg)
        begin
            wr_ent.pos_x = sat_add(s3_ent_reg.pos_x, s3_dx_reg);
            wr_ent.pos_y = sat_add(s3_ent_reg.pos_y, s3_dy_reg);
            wr_ent.life  = s3_ent_reg.life - LIFE_W'(cfg.tick_ms);
        end
    end

    assign wr_en    = adv && s3_valid_reg && s3_wr_reg;
    assign wr_alive = (wr_ent.life > 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[s3_idx_reg] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot_index_reg <= SLOT_IDX_W'(s3_idx_reg);
            alive_reg      <= wr_alive;
            pos_x_reg      <= wr_alive ? wr_ent.pos_x : '0;
            pos_y_reg      <= wr_alive ? wr_ent.pos_y : '0;
            life_left_reg  <= wr_ent.life;
            last_reg       <= (s3_idx_reg == IDX_W'(SLOTS - 1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = slot_index_reg;
    assign alive      = alive_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign life_left  = life_left_reg;
    assign last       = last_reg;

endmodule

### design/particle_emitter_step.sv
`timescale 1ns / 1ps

// Damped particle emitter, one pool of SLOTS slots.
// Input channel (in_valid / in_ready, emitter_on): one item is one tick.
// On each accepted tick the emission timer is updated, then all slots are
// swept in slot order; a due emission lands in the first free slot found.
// Output channel (out_valid / out_ready): SLOTS items per tick, one per slot,
// in slot order, with last set on the final slot.
// Slot state lives in one memory with a registered read; each slot goes
// through read, damp, step and write-back stages, one slot per cycle while
// the receiver does not stall. Each slot passes through the sequencer,
// memory read, damp, step and output registers; the next tick waits until
// the sweep of the slot memory has drained from the pipeline.
// When the receiver stalls the whole sweep holds in place; the next tick is
// taken while the last result still waits in the output register.
// Reset clears the timer, the sequencer and the per-slot valid bits, so every
// slot reads as free; configuration registers return to defaults. The user
// writes them via cfg_we / cfg_index / cfg_data while idle; not enforced.

module particle_emitter_step
    import pes_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         emitter_on,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SLOT_IDX_W-1:0]        slot_index,
    output logic                         alive,
    output logic signed [POS_W-1:0]      pos_x,
    output logic signed [POS_W-1:0]      pos_y,
    output logic signed [LIFE_W-1:0]     life_left,
    output logic                         last
);

    cfg_t       cfg_reg;
    issue_t     iss;
    pipe_stat_t stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emit_interval_ms <= 16'd100;
            cfg_reg.lifetime_ms      <= 20'd1000;
            cfg_reg.start_x          <= '0;
            cfg_reg.start_y          <= '0;
            cfg_reg.start_vel_x      <= '0;
            cfg_reg.start_vel_y      <= '0;
            cfg_reg.tick_ms          <= 10'd16;
            cfg_reg.tick_seconds     <= 16'd1049;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EMIT_INTERVAL: cfg_reg.emit_interval_ms <= cfg_data[15:0];
                REG_LIFETIME:      cfg_reg.lifetime_ms      <= cfg_data[19:0];
                REG_START_X:       cfg_reg.start_x          <= cfg_data;
                REG_START_Y:       cfg_reg.start_y          <= cfg_data;
                REG_START_VEL_X:   cfg_reg.start_vel_x      <= cfg_data;
                REG_START_VEL_Y:   cfg_reg.start_vel_y      <= cfg_data;
                REG_TICK_MS:       cfg_reg.tick_ms          <= cfg_data[9:0];
                REG_TICK_SECONDS:  cfg_reg.tick_seconds     <= cfg_data[15:0];
                default:
                begin
                    cfg_reg.tick_seconds <= cfg_reg.tick_seconds;
                end
            endcase
        end
    end

    pes_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .emitter_on (emitter_on),
        .stat       (stat),
        .iss        (iss)
    );

    pes_slot_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .iss        (iss),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_index (slot_index),
        .alive      (alive),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .life_left  (life_left),
        .last       (last)
    );

    // A tick in progress blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a tick was accepted");

    // The final slot leaves only an empty pipe behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !stat.busy)
        else $error("slots still in flight behind the final slot");

    // Alive flag agrees with the reported life
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alive == (life_left > 0)))
        else $error("alive flag does not match remaining life");

    // Sweep never issues a slot while a new tick starts
    assert property (@(posedge clk) disable iff (!rst_n)
        iss.start |-> !iss.valid && !stat.busy)
        else $error("tick started during a sweep");

endmodule
